// ----- hw/rtl/pnmsd_pkg.sv -----
// Shared types and constants of the PNM sample decoder.
package pnmsd_pkg;

	localparam int COLUMN_BITS_DEF = 16;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 16;

	localparam logic [1:0] REG_FORMAT   = 2'd0;
	localparam logic [1:0] REG_CHANNELS = 2'd1;
	localparam logic [1:0] REG_MAXVAL   = 2'd2;
	localparam logic [1:0] REG_ROWW     = 2'd3;

	localparam logic [1:0] MODE_ASCII_BIT    = 2'd0;
	localparam logic [1:0] MODE_ASCII_GRAY   = 2'd1;
	localparam logic [1:0] MODE_RAW_BIT      = 2'd2;
	localparam logic [1:0] MODE_RAW_SAMPLE   = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [15:0] TOKEN_LIMIT = 16'd6553;
	localparam logic [15:0] BYTE_MAX    = 16'd255;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ERROR,
		ACT_DIRECT,
		ACT_SCALE,
		ACT_BITMAP
	} act_t;

	typedef struct packed {
		logic eval;
		logic div_init;
		logic div_step;
		logic slot_out;
		logic bit_out;
		logic err_out;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic out_free;
		logic step_last;
	} sts_t;

endpackage

// ----- hw/rtl/pnmsd_datapath.sv -----
// Datapath of the PNM sample decoder: token parser, scaler, pixel position and output register.
module pnmsd_datapath #(
	parameter int COLUMN_BITS = pnmsd_pkg::COLUMN_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pnmsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pnmsd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [7:0]                         in_byte,
	input  pnmsd_pkg::cmd_t                    cmd,
	output pnmsd_pkg::sts_t                    sts,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [7:0]                         m_tdata,
	output logic                               m_tlast,
	output logic [1:0]                         m_tuser
);
	import pnmsd_pkg::*;

	logic [1:0]  format_q;
	logic [2:0]  chan_q;
	logic [15:0] maxval_q;
	logic [15:0] roww_q;

	logic [15:0] token_q;
	logic        digit_q;
	logic        comment_q;
	logic [7:0]  high_q;
	logic        phase_q;
	logic [1:0]  chidx_q;
	logic [COLUMN_BITS-1:0] col_q;

	logic [15:0] val_q;
	logic        scaled_q;
	logic [7:0]  shift_q;
	logic [2:0]  step_q;
	logic        ended_q;
	logic [15:0] rem_q;
	logic [7:0]  low_q;
	logic [7:0]  quo_q;
	logic        sat_q;
	logic        zero_q;

	logic        out_valid_q;
	logic [7:0]  out_sample_q;
	logic        out_row_q;
	logic        out_run_q;
	logic        out_err_q;

	act_t        act;
	logic [15:0] tok_d;
	logic        dig_d;
	logic        com_d;
	logic [7:0]  hi_d;
	logic        ph_d;
	logic [15:0] val_d;
	logic        is_digit;
	logic        is_space;
	logic        overflow;
	logic [15:0] tok_x10;
	act_t        token_act;

	logic [23:0] prod;
	logic [16:0] r2;
	logic        ge;

	logic [2:0]  ch_lim;
	logic [2:0]  idx;
	logic [2:0]  lastch;
	logic [2:0]  idx_inc;
	logic        skip;
	logic        pixel_done;
	logic [COLUMN_BITS-1:0] last_col;
	logic        col_end;
	logic        slot_row_last;
	logic [7:0]  slot_sample;
	logic        out_free;
	logic        load;

	assign out_free = !out_valid_q || m_tready;

	// ascii tokens, comments, raw bitmap bytes and raw one- or two-byte sample assembly
	always_comb begin
		act      = ACT_NONE;
		tok_d    = token_q;
		dig_d    = digit_q;
		com_d    = comment_q;
		hi_d     = high_q;
		ph_d     = phase_q;
		val_d    = val_q;
		is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		is_space = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
		           (in_byte == CH_CR) || (in_byte == CH_LF);
		overflow = (token_q > TOKEN_LIMIT) || ((token_q == TOKEN_LIMIT) && (in_byte >= CH_SIX));
		tok_x10  = {token_q[12:0], 3'b000} + {token_q[14:0], 1'b0};
		token_act = (format_q == MODE_ASCII_BIT) ? ACT_DIRECT : ACT_SCALE;
		if ((format_q == MODE_ASCII_BIT) || (format_q == MODE_ASCII_GRAY)) begin
			if (in_byte == CH_NUL) begin
				act   = ACT_ERROR;
				tok_d = '0;
				dig_d = 1'b0;
				com_d = 1'b0;
			end else if (comment_q) begin
				if (in_byte <= CH_LF) begin
					com_d = 1'b0;
				end
			end else if ((in_byte == CH_HASH) || is_space) begin
				if (digit_q) begin
					act   = token_act;
					val_d = token_q;
					tok_d = '0;
					dig_d = 1'b0;
				end
				if (in_byte == CH_HASH) begin
					com_d = 1'b1;
				end
			end else if (is_digit) begin
				if (overflow) begin
					act   = ACT_ERROR;
					tok_d = '0;
					dig_d = 1'b0;
					com_d = 1'b0;
				end else begin
					tok_d = tok_x10 + {12'd0, in_byte[3:0]};
					dig_d = 1'b1;
				end
			end
		end else if (format_q == MODE_RAW_BIT) begin
			act = ACT_BITMAP;
		end else if (maxval_q > BYTE_MAX) begin
			if (!phase_q) begin
				hi_d = in_byte;
				ph_d = 1'b1;
			end else begin
				ph_d  = 1'b0;
				val_d = {high_q, in_byte};
				act   = ACT_SCALE;
			end
		end else begin
			val_d = {8'd0, in_byte};
			act   = ACT_SCALE;
		end
	end

	// scaler: v*255 by shift and subtract, then one quotient bit per step
	assign prod = {val_q, 8'd0} - {8'd0, val_q};
	assign r2   = {rem_q, low_q[7]};
	assign ge   = r2 >= {1'b0, maxval_q};

	// channel slot and column
	always_comb begin
		if ((format_q == MODE_ASCII_GRAY) || (format_q == MODE_RAW_SAMPLE)) begin
			if (chan_q == 3'd0) begin
				ch_lim = 3'd1;
			end else if (chan_q > 3'd4) begin
				ch_lim = 3'd4;
			end else begin
				ch_lim = chan_q;
			end
		end else begin
			ch_lim = 3'd1;
		end
		idx        = ({1'b0, chidx_q} >= ch_lim) ? 3'd0 : {1'b0, chidx_q};
		lastch     = (ch_lim == 3'd4) ? 3'd2 : (ch_lim - 3'd1);
		skip       = (ch_lim == 3'd4) && (idx == 3'd3);
		idx_inc    = idx + 3'd1;
		pixel_done = idx_inc >= ch_lim;
	end

	assign last_col      = roww_q[COLUMN_BITS-1:0] - COLUMN_BITS'(1);
	assign col_end       = col_q == last_col;
	assign slot_row_last = (idx == lastch) && col_end;
	assign slot_sample   = !scaled_q ? val_q[7:0] :
	                       zero_q    ? 8'd0 :
	                       sat_q     ? 8'hff : quo_q;

	assign load = cmd.err_out || cmd.bit_out || (cmd.slot_out && !skip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q  <= MODE_RAW_SAMPLE;
			chan_q    <= 3'd3;
			maxval_q  <= 16'd255;
			roww_q    <= 16'd1;
			token_q   <= '0;
			digit_q   <= 1'b0;
			comment_q <= 1'b0;
			high_q    <= '0;
			phase_q   <= 1'b0;
			chidx_q   <= '0;
			col_q     <= '0;
			step_q    <= '0;
			ended_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FORMAT:   format_q <= cfg_data[1:0];
					REG_CHANNELS: chan_q   <= cfg_data[2:0];
					REG_MAXVAL:   maxval_q <= cfg_data;
					REG_ROWW:     roww_q   <= cfg_data;
				endcase
			end
			if (cmd.eval) begin
				token_q   <= tok_d;
				digit_q   <= dig_d;
				comment_q <= com_d;
				high_q    <= hi_d;
				phase_q   <= ph_d;
				step_q    <= '0;
				ended_q   <= 1'b0;
				if (act == ACT_BITMAP) begin
					chidx_q <= '0;
				end
			end else if (cmd.div_init) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 3'd1;
			end else if (cmd.slot_out) begin
				chidx_q <= pixel_done ? 2'd0 : idx_inc[1:0];
				if (pixel_done) begin
					col_q <= col_end ? '0 : col_q + COLUMN_BITS'(1);
				end
			end else if (cmd.bit_out) begin
				step_q <= step_q + 3'd1;
				if (!ended_q) begin
					if (col_end) begin
						ended_q <= 1'b1;
						col_q   <= '0;
					end else begin
						col_q <= col_q + COLUMN_BITS'(1);
					end
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			val_q    <= val_d;
			scaled_q <= act == ACT_SCALE;
			shift_q  <= in_byte;
		end
		if (cmd.div_init) begin
			rem_q  <= prod[23:8];
			low_q  <= prod[7:0];
			sat_q  <= prod[23:8] >= maxval_q;
			zero_q <= val_q == 16'd0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? 16'(r2 - {1'b0, maxval_q}) : r2[15:0];
			low_q <= {low_q[6:0], 1'b0};
			quo_q <= {quo_q[6:0], ge};
		end
		if (cmd.bit_out) begin
			shift_q <= {shift_q[6:0], 1'b0};
		end
		if (cmd.err_out) begin
			out_sample_q <= 8'd0;
			out_row_q    <= 1'b0;
			out_run_q    <= 1'b1;
			out_err_q    <= 1'b1;
		end else if (cmd.slot_out) begin
			out_sample_q <= slot_sample;
			out_row_q    <= slot_row_last;
			out_run_q    <= 1'b1;
			out_err_q    <= 1'b0;
		end else if (cmd.bit_out) begin
			out_sample_q <= {7'd0, shift_q[7]};
			out_row_q    <= (step_q == 3'd7) && (ended_q || col_end);
			out_run_q    <= step_q == 3'd7;
			out_err_q    <= 1'b0;
		end
	end

	assign sts.act       = act;
	assign sts.out_free  = out_free;
	assign sts.step_last = step_q == 3'd7;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sample_q;
	assign m_tlast  = out_run_q;
	assign m_tuser  = {out_err_q, out_row_q};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(load && out_valid_q && !m_tready))
		else $error("output register loaded while a request is held");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (out_sample_q == 8'd0 && out_run_q && !out_row_q))
		else $error("error result carries data");

endmodule

// ----- hw/rtl/pnmsd_ctrl.sv -----
// Controller of the PNM sample decoder: sequences accept, scaling and result output.
module pnmsd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pnmsd_pkg::sts_t sts,
	output pnmsd_pkg::cmd_t cmd
);
	import pnmsd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_DINIT,
		ST_DIV,
		ST_SLOT,
		ST_BITS
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign in_ready = ready_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.eval     = in_valid;
			ST_ERR:   cmd.err_out  = sts.out_free;
			ST_DINIT: cmd.div_init = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_SLOT:  cmd.slot_out = sts.out_free;
			ST_BITS:  cmd.bit_out  = sts.out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (sts.act)
							ACT_NONE:   state_q <= ST_IDLE;
							ACT_ERROR:  state_q <= ST_ERR;
							ACT_DIRECT: state_q <= ST_SLOT;
							ACT_SCALE:  state_q <= ST_DINIT;
							ACT_BITMAP: state_q <= ST_BITS;
							default:    state_q <= ST_IDLE;
						endcase
						ready_q <= sts.act == ACT_NONE;
					end
				end
				ST_DINIT: state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.step_last) begin
						state_q <= ST_SLOT;
					end
				end
				ST_ERR, ST_SLOT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_BITS: begin
					if (sts.out_free && sts.step_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
			endcase
		end
	end

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DINIT) |-> ##9 (state_q == ST_SLOT))
		else $error("scaling did not take eight steps");

	a_bits_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BITS && sts.out_free && sts.step_last) |=>
		(state_q == ST_IDLE && in_ready))
		else $error("bitmap byte not closed after eighth sample");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_IDLE))
		else $error("ready outside idle");

endmodule

// ----- hw/rtl/pnm_sample_decoder_top.sv -----
// Top level of the PNM sample decoder.
// Feeds on the raster bytes of a PNM or PAM file after its header and gives
// 8-bit samples on a stream output.
// Input stream: one raster byte per request on s_tdata.
// Output stream: m_tdata is the sample, m_tlast marks the final result of
// an input byte, m_tuser carries the row end and ascii error flags.
// Configuration: cfg_we with cfg_index and cfg_data writes one register
// (format, channel count, maxval, row width); write only while idle.
// Steps per byte:
//   ascii byte with no token end: taken in the idle state.
//   token end or raw sample: a divider init state, then the restoring divider
//   that gives one quotient bit per cycle for eight bits, then the output state.
//   ascii bitmap token or error: the output state follows acceptance.
//   raw bitmap byte: one output sample per cycle while the receiver takes them.
// One byte is worked on at a time; the next is taken while the last result
// waits in the output register. A stalled receiver holds the controller in
// its output state. Reset clears the parser, pixel position and output
// valid flag and loads the register defaults.
module pnm_sample_decoder_top #(
	parameter int COLUMN_BITS = pnmsd_pkg::COLUMN_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // file_byte
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata,   // sample
	output logic                               m_tlast,   // run_last
	output logic [1:0]                         m_tuser,   // parse_error, row_last
	input  logic                               cfg_we,
	input  logic [pnmsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pnmsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pnmsd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pnmsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pnmsd_datapath #(
		.COLUMN_BITS (COLUMN_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_byte   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
